@@ rtl/core/b3h_pkg.sv @@
`default_nettype none
package b3h_pkg;

  localparam int Lanes = 4;

  localparam logic [2:0] CfgKey01   = 3'd0;
  localparam logic [2:0] CfgKey23   = 3'd1;
  localparam logic [2:0] CfgKey45   = 3'd2;
  localparam logic [2:0] CfgKey67   = 3'd3;
  localparam logic [2:0] CfgCtrBase = 3'd4;
  localparam logic [2:0] CfgCtrLane = 3'd5;
  localparam logic [2:0] CfgFlags   = 3'd6;
  localparam logic [2:0] CfgEdge    = 3'd7;

  localparam logic [31:0] BlockBytes = 32'd64;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] block_t;

  // One queued block job for the compression engine.
  typedef struct packed {
    block_t [Lanes-1:0] msg;
    logic               first;
    logic               fin;
    logic [2:0]         used;
  } job_t;

  function automatic word_t iv_word(input logic [1:0] i);
    case (i)
      2'd0:    iv_word = 32'h6A09E667;
      2'd1:    iv_word = 32'hBB67AE85;
      2'd2:    iv_word = 32'h3C6EF372;
      default: iv_word = 32'hA54FF53A;
    endcase
  endfunction

  function automatic logic [3:0] perm_idx(input logic [3:0] i);
    case (i)
      4'd0:  perm_idx = 4'd2;
      4'd1:  perm_idx = 4'd6;
      4'd2:  perm_idx = 4'd3;
      4'd3:  perm_idx = 4'd10;
      4'd4:  perm_idx = 4'd7;
      4'd5:  perm_idx = 4'd0;
      4'd6:  perm_idx = 4'd4;
      4'd7:  perm_idx = 4'd13;
      4'd8:  perm_idx = 4'd1;
      4'd9:  perm_idx = 4'd11;
      4'd10: perm_idx = 4'd12;
      4'd11: perm_idx = 4'd5;
      4'd12: perm_idx = 4'd9;
      4'd13: perm_idx = 4'd14;
      4'd14: perm_idx = 4'd15;
      default: perm_idx = 4'd8;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/blake3_four_lane_chunk_hasher.sv @@
`default_nettype none
// Four-lane BLAKE3 chunk hasher. Each input beat carries message word j of the
// current 64-byte block for all four lanes; after sixteen beats the block is
// handed through a one-entry job register to the compression engine, which
// runs 7 rounds of 8 G functions as 112 half-mix steps, one step per cycle,
// all lanes in parallel. The front can collect the next block while the engine
// mixes. On a final block the engine emits eight output beats, one per cycle
// when not stalled, chaining-value words 0..7 for each lane, with lanes beyond
// lanes_in_use zeroed. Key registers are sampled at the first block of each
// batch; the user must write configuration over cfg_valid/cfg_ready only
// while idle, which the block itself does not enforce.
module blake3_four_lane_chunk_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] word_lane_a,
  input  wire logic [31:0] word_lane_b,
  input  wire logic [31:0] word_lane_c,
  input  wire logic [31:0] word_lane_d,
  input  wire logic        final_block,
  input  wire logic [2:0]  lanes_in_use,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      hash_lane_a,
  output logic [31:0]      hash_lane_b,
  output logic [31:0]      hash_lane_c,
  output logic [31:0]      hash_lane_d,
  output logic [2:0]       word_number,
  output logic             last_word,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  logic [255:0] key;
  logic [63:0]  counter_base;
  logic         counter_per_lane;
  logic [7:0]   flags_common;
  logic [15:0]  edge_flags;
  logic         job_valid;
  logic         job_ready;
  b3h_pkg::job_t job;

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
      counter_base <= '0;
      counter_per_lane <= 1'b0;
      flags_common <= '0;
      edge_flags <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        b3h_pkg::CfgKey01:   key[63:0] <= cfg_data;
        b3h_pkg::CfgKey23:   key[127:64] <= cfg_data;
        b3h_pkg::CfgKey45:   key[191:128] <= cfg_data;
        b3h_pkg::CfgKey67:   key[255:192] <= cfg_data;
        b3h_pkg::CfgCtrBase: counter_base <= cfg_data;
        b3h_pkg::CfgCtrLane: counter_per_lane <= cfg_data[0];
        b3h_pkg::CfgFlags:   flags_common <= cfg_data[7:0];
        default:             edge_flags <= cfg_data[15:0];
      endcase
    end
  end

  b3h_front u_front (
    .clk, .rst, .in_valid, .in_stall,
    .word_lane_a, .word_lane_b, .word_lane_c, .word_lane_d,
    .final_block, .lanes_in_use,
    .job_valid, .job, .job_ready
  );

  b3h_back u_back (
    .clk, .rst, .job_valid, .job, .job_ready,
    .key, .counter_base, .counter_per_lane, .flags_common, .edge_flags,
    .out_valid, .out_stall,
    .hash_lane_a, .hash_lane_b, .hash_lane_c, .hash_lane_d,
    .word_number, .last_word
  );
endmodule
`default_nettype wire

@@ rtl/core/b3h_front.sv @@
`default_nettype none
// Collects sixteen word beats into one block job and pushes it to the queue.
module b3h_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [31:0]         word_lane_a,
  input  wire logic [31:0]         word_lane_b,
  input  wire logic [31:0]         word_lane_c,
  input  wire logic [31:0]         word_lane_d,
  input  wire logic                final_block,
  input  wire logic [2:0]          lanes_in_use,
  output logic                     job_valid,
  output b3h_pkg::job_t            job,
  input  wire logic                job_ready
);
  logic [3:0] word_position;
  logic       first_pending;
  logic       acc;

  assign in_stall = job_valid;
  assign acc = in_valid && !in_stall;

  // words land straight in the job register; it only fills while no job waits
  always_ff @(posedge clk) begin
    if (rst) begin
      word_position <= '0;
      first_pending <= 1'b1;
      job_valid <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        job_valid <= 1'b0;
      end
      if (acc) begin
        word_position <= word_position + 4'd1;
        job.msg[0][word_position] <= word_lane_a;
        job.msg[1][word_position] <= word_lane_b;
        job.msg[2][word_position] <= word_lane_c;
        job.msg[3][word_position] <= word_lane_d;
        if (word_position == 4'd15) begin
          job_valid <= 1'b1;
          job.first <= first_pending;
          job.fin <= final_block;
          job.used <= (lanes_in_use > 3'd4) ? 3'd4 : lanes_in_use;
          first_pending <= final_block;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    acc && word_position == 4'd15 |=> job_valid && word_position == 4'd0)
    else $error("block job not raised on sixteenth word");
  a_nodrop: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_ready |=> job_valid)
    else $error("job dropped");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> in_stall)
    else $error("word taken while job pending");
`endif
endmodule
`default_nettype wire

@@ rtl/core/b3h_back.sv @@
`default_nettype none
// Compression engine: one G half-mix/lane/cycle, then 8 output beats if final.
module b3h_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                job_valid,
  input  wire b3h_pkg::job_t       job,
  output logic                     job_ready,
  input  wire logic [255:0]        key,
  input  wire logic [63:0]         counter_base,
  input  wire logic                counter_per_lane,
  input  wire logic [7:0]          flags_common,
  input  wire logic [15:0]         edge_flags,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [31:0]              hash_lane_a,
  output logic [31:0]              hash_lane_b,
  output logic [31:0]              hash_lane_c,
  output logic [31:0]              hash_lane_d,
  output logic [2:0]               word_number,
  output logic                     last_word
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMix  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0] state;
  logic [2:0] round;
  logic [2:0] gsel;
  logic       half;
  logic [2:0] used;
  logic       fin;
  logic [63:0] batch_offset;
  logic [2:0] oidx;
  b3h_pkg::word_t chain [b3h_pkg::Lanes][8];
  b3h_pkg::word_t v [b3h_pkg::Lanes][16];
  b3h_pkg::block_t m [b3h_pkg::Lanes];

  logic [3:0] ia, ib, ic, id, im;
  b3h_pkg::word_t na [b3h_pkg::Lanes];
  b3h_pkg::word_t nb [b3h_pkg::Lanes];
  b3h_pkg::word_t nc [b3h_pkg::Lanes];
  b3h_pkg::word_t nd [b3h_pkg::Lanes];
  logic [7:0] flags;
  logic [63:0] ctr [b3h_pkg::Lanes];

  function automatic b3h_pkg::word_t rotr(input b3h_pkg::word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  assign job_ready = (state == StIdle);

  always_comb begin
    unique case (gsel)
      3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
      3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
      3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
      3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
      3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
      3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
      3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
      default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
    endcase
    im = {gsel, half};
  end

  always_comb begin
    for (int l = 0; l < b3h_pkg::Lanes; l++) begin
      na[l] = v[l][ia] + v[l][ib] + m[l][im];
      if (!half) begin
        nd[l] = rotr(v[l][id] ^ na[l], 16);
      end else begin
        nd[l] = rotr(v[l][id] ^ na[l], 8);
      end
      nc[l] = v[l][ic] + nd[l];
      if (!half) begin
        nb[l] = rotr(v[l][ib] ^ nc[l], 12);
      end else begin
        nb[l] = rotr(v[l][ib] ^ nc[l], 7);
      end
    end
  end

  always_comb begin
    flags = flags_common;
    if (job.first) flags = flags | edge_flags[7:0];
    if (job.fin) flags = flags | edge_flags[15:8];
    for (int l = 0; l < b3h_pkg::Lanes; l++) begin
      ctr[l] = counter_per_lane ? (counter_base + batch_offset + 64'(l)) : counter_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      batch_offset <= '0;
      out_valid <= 1'b0;
      round <= '0;
      gsel <= '0;
      half <= 1'b0;
      used <= '0;
      fin <= 1'b0;
      oidx <= '0;
    end else begin
      unique case (state)
        StIdle: begin
          if (job_valid) begin
            state <= StMix;
            round <= '0;
            gsel <= '0;
            half <= 1'b0;
            used <= job.used;
            fin <= job.fin;
          end
        end
        StMix: begin
          half <= !half;
          if (half) begin
            gsel <= gsel + 3'd1;
            if (gsel == 3'd7) begin
              round <= round + 3'd1;
              if (round == 3'd6) begin
                if (fin) begin
                  state <= StOut;
                  oidx <= '0;
                  out_valid <= 1'b1;
                end else begin
                  state <= StIdle;
                end
              end
            end
          end
        end
        StOut: begin
          if (!out_stall) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              out_valid <= 1'b0;
              state <= StIdle;
              batch_offset <= batch_offset + 64'(b3h_pkg::Lanes);
            end
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < b3h_pkg::Lanes; l++) begin
      if (state == StIdle && job_valid) begin
        m[l] <= job.msg[l];
        for (int i = 0; i < 8; i++) begin
          v[l][i] <= job.first ? key[32*i +: 32] : chain[l][i];
        end
        for (int i = 0; i < 4; i++) v[l][8+i] <= b3h_pkg::iv_word(2'(i));
        v[l][12] <= ctr[l][31:0];
        v[l][13] <= ctr[l][63:32];
        v[l][14] <= b3h_pkg::BlockBytes;
        v[l][15] <= {24'd0, flags};
      end else if (state == StMix) begin
        v[l][ia] <= na[l];
        v[l][ib] <= nb[l];
        v[l][ic] <= nc[l];
        v[l][id] <= nd[l];
        if (half && gsel == 3'd7) begin
          for (int i = 0; i < 16; i++) m[l][i] <= m[l][b3h_pkg::perm_idx(4'(i))];
          if (round == 3'd6) begin
            // last step mixes words 3, 4, 9 and 14; fold them in fresh
            chain[l][0] <= v[l][0] ^ v[l][8];
            chain[l][1] <= v[l][1] ^ nc[l];
            chain[l][2] <= v[l][2] ^ v[l][10];
            chain[l][3] <= na[l] ^ v[l][11];
            chain[l][4] <= nb[l] ^ v[l][12];
            chain[l][5] <= v[l][5] ^ v[l][13];
            chain[l][6] <= v[l][6] ^ nd[l];
            chain[l][7] <= v[l][7] ^ v[l][15];
          end
        end
      end
    end
  end

  always_comb begin
    hash_lane_a = (used > 3'd0) ? chain[0][oidx] : '0;
    hash_lane_b = (used > 3'd1) ? chain[1][oidx] : '0;
    hash_lane_c = (used > 3'd2) ? chain[2][oidx] : '0;
    hash_lane_d = (used > 3'd3) ? chain[3][oidx] : '0;
    word_number = oidx;
    last_word = (oidx == 3'd7);
  end

`ifndef SYNTHESIS
  a_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == StOut)
    else $error("output beat outside output phase");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(oidx))
    else $error("output index moved under stall");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state == StMix |-> !job_ready)
    else $error("engine ready while mixing");
`endif
endmodule
`default_nettype wire
